// File: design/fsa_pkg.sv
package fsa_pkg;
  localparam int CellBits    = 32;
  localparam int DataDepth   = 32;
  localparam int ReturnDepth = 32;
  localparam int DataAw      = $clog2(DataDepth);
  localparam int ReturnAw    = $clog2(ReturnDepth);
  localparam int DataCw      = $clog2(DataDepth + 1);
  localparam int ReturnCw    = $clog2(ReturnDepth + 1);
  localparam int ShiftCw     = $clog2(CellBits + 1);

  typedef logic [CellBits-1:0] cell_t;

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,  OP_DROP  = 5'd1,  OP_DUP   = 5'd2,  OP_SWAP  = 5'd3,
    OP_OVER  = 5'd4,  OP_QDUP  = 5'd5,  OP_AND   = 5'd6,  OP_OR    = 5'd7,
    OP_XOR   = 5'd8,  OP_NOT   = 5'd9,  OP_SHIFT = 5'd10, OP_ADD   = 5'd11,
    OP_SUB   = 5'd12, OP_NEG   = 5'd13, OP_DIVMOD = 5'd14, OP_DIV  = 5'd15,
    OP_MOD   = 5'd16, OP_MUL   = 5'd17, OP_ABS   = 5'd18, OP_MAX   = 5'd19,
    OP_MIN   = 5'd20, OP_EQ    = 5'd21, OP_LT    = 5'd22, OP_GT    = 5'd23,
    OP_TOR   = 5'd24, OP_RFETCH = 5'd25, OP_RFROM = 5'd26, OP_DCLR = 5'd27,
    OP_RCLR  = 5'd28, OP_NOP29 = 5'd29, OP_NOP30 = 5'd30, OP_NOP31 = 5'd31
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DUNDER = 3'd1, ST_DOVER = 3'd2,
    ST_RUNDER = 3'd3, ST_ROVER = 3'd4, ST_DIVZ = 3'd5
  } status_t;
endpackage

// File: design/fsa_if.sv
interface fsa_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] mode;
  logic [31:0] literal;
  modport source(output valid, mode, literal, input ready);
  modport sink(input valid, mode, literal, output ready);
endinterface

interface fsa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] top_value;
  logic [31:0] popped_value;
  logic [5:0]  data_count;
  logic [5:0]  return_count;
  logic [2:0]  status;
  modport source(output valid, top_value, popped_value, data_count, return_count, status,
                 input ready);
  modport sink(input valid, top_value, popped_value, data_count, return_count, status,
               output ready);
endinterface

// File: design/fsa_ram.sv
module fsa_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/fsa_alu.sv
module fsa_alu
  import fsa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  opcode_t op,
  input  cell_t   a,
  input  cell_t   b,
  output logic    done,
  output cell_t   result,
  output cell_t   remainder
);
  typedef enum logic [1:0] {IDLE, MULT, DIVIDE, FINISH} alu_state_t;

  localparam int CntW = $clog2(CellBits + 1);

  alu_state_t      state;
  logic [CntW-1:0] count;
  cell_t           acc;
  cell_t           mcand;
  cell_t           mplier;
  cell_t           rem;
  logic [CellBits:0] trial;
  logic            lt_ab;
  logic            lt_ba;
  logic [CellBits-1:0] neg_b;

  assign trial = {1'b0, rem[CellBits-2:0], mplier[CellBits-1]} - {1'b0, mcand};
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);
  assign neg_b = -b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            count  <= CntW'(CellBits);
            mcand  <= (op == OP_MUL) ? a : b;
            mplier <= (op == OP_MUL) ? b : a;
            acc    <= '0;
            rem    <= '0;
            case (op)
              OP_MUL: state <= MULT;
              OP_DIVMOD, OP_DIV, OP_MOD: state <= DIVIDE;
              default: begin
                state <= FINISH;
                case (op)
                  OP_AND: acc <= a & b;
                  OP_OR:  acc <= a | b;
                  OP_XOR: acc <= a ^ b;
                  OP_ADD: acc <= a + b;
                  OP_SUB: acc <= a - b;
                  OP_MAX: acc <= lt_ab ? b : a;
                  OP_MIN: acc <= lt_ba ? b : a;
                  OP_EQ:  acc <= cell_t'(a == b);
                  OP_LT:  acc <= cell_t'(lt_ab);
                  OP_GT:  acc <= cell_t'(lt_ba);
                  OP_SHIFT: begin
                    if (b[CellBits-1]) begin
                      acc <= (neg_b >= CellBits) ? '0 : a >> neg_b[ShiftCw-1:0];
                    end else begin
                      acc <= (b >= CellBits) ? '0 : a << b[ShiftCw-1:0];
                    end
                  end
                  default: acc <= '0;
                endcase
              end
            endcase
          end
        end
        MULT: begin
          // shift-add, one multiplier bit per cycle
          if (mplier[0]) acc <= acc + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          count  <= count - CntW'(1);
          if (count == CntW'(1)) state <= FINISH;
        end
        DIVIDE: begin
          // restoring divide, one quotient bit per cycle
          if (!trial[CellBits] || rem[CellBits-1]) begin
            rem <= trial[CellBits-1:0];
            acc <= {acc[CellBits-2:0], 1'b1};
          end else begin
            rem <= {rem[CellBits-2:0], mplier[CellBits-1]};
            acc <= {acc[CellBits-2:0], 1'b0};
          end
          mplier <= mplier << 1;
          count  <= count - CntW'(1);
          if (count == CntW'(1)) state <= FINISH;
        end
        FINISH: begin
          done  <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign result    = (op == OP_MOD) ? rem : acc;
  assign remainder = rem;
endmodule

// File: design/forth_stack_alu.sv
// Forth-style stack execution unit with a data stack and a return stack.
// Channel in: one transaction carries mode (opcode) and literal.
// Channel out: one transaction per input item with the new data stack top,
// the value removed by drop, both stack depths and a status code.
// One item at a time: in.ready is high only while the unit is idle.
// Steps: READ_T, READ_N and WAIT_N read top, next and return top; CHECK
// tests faults and does stack-only ops, swap adds WRITE2; logic/add/compare/
// shift, multiply, / and mod run EXEC and ALU_WAIT on the shared shift-add /
// restoring divide unit, one bit per cycle, and /mod adds WRITE2. The stack
// RAMs have a write port and a registered read port; REFRESH and REFRESH_W
// re-read the new top, then RESULT does the handshake and returns to IDLE.
// Faults (underflow, overflow, divide by zero) leave both stacks unchanged.
// Reset clears both depth counters; stack contents are not cleared and are
// only used below the depth counter.
// A stalled result holds on the out channel; no new item is taken until it
// is delivered.
module forth_stack_alu
  import fsa_pkg::*;
(
  input logic   clk,
  input logic   rst,
  fsa_in_if.sink    in,
  fsa_out_if.source out
);
  typedef enum logic [3:0] {
    IDLE, READ_T, READ_N, WAIT_N, CHECK, EXEC, ALU_WAIT, WRITE2, REFRESH, REFRESH_W, RESULT
  } state_t;

  state_t  state;
  opcode_t op;
  cell_t   lit;
  cell_t   top;
  cell_t   nxt;
  cell_t   rtop;
  cell_t   wval2;
  logic [DataCw-1:0]   dp;
  logic [ReturnCw-1:0] rp;

  logic              d_we;
  logic [DataAw-1:0] d_waddr;
  cell_t             d_wdata;
  logic [DataAw-1:0] d_raddr;
  cell_t             d_rdata;
  logic                r_we;
  logic [ReturnAw-1:0] r_waddr;
  cell_t               r_wdata;
  logic [ReturnAw-1:0] r_raddr;
  cell_t               r_rdata;

  logic  alu_start;
  logic  alu_done;
  cell_t alu_res;
  cell_t alu_rem;

  fsa_ram #(.Width(CellBits), .Depth(DataDepth)) u_dstack (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );
  fsa_ram #(.Width(CellBits), .Depth(ReturnDepth)) u_rstack (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );
  fsa_alu u_alu (
    .clk(clk), .rst(rst), .start(alu_start), .op(op), .a(nxt), .b(top),
    .done(alu_done), .result(alu_res), .remainder(alu_rem)
  );

  localparam logic [DataCw-1:0]   DFull = DataCw'(DataDepth);
  localparam logic [ReturnCw-1:0] RFull = ReturnCw'(ReturnDepth);

  logic [DataCw-1:0]   dp_m1;
  logic [DataCw-1:0]   dp_m2;
  logic [DataCw-1:0]   dp_p1;
  logic [ReturnCw-1:0] rp_m1;
  logic [ReturnCw-1:0] rp_p1;
  assign dp_m1 = dp - DataCw'(1);
  assign dp_m2 = dp - DataCw'(2);
  assign dp_p1 = dp + DataCw'(1);
  assign rp_m1 = rp - ReturnCw'(1);
  assign rp_p1 = rp + ReturnCw'(1);

  // read address: top in READ_T, next in READ_N, new top in REFRESH
  always_comb begin
    case (state)
      READ_N:  d_raddr = dp_m2[DataAw-1:0];
      default: d_raddr = dp_m1[DataAw-1:0];
    endcase
  end
  assign r_raddr = rp_m1[ReturnAw-1:0];

  assign in.ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      dp        <= '0;
      rp        <= '0;
      out.valid <= 1'b0;
      d_we      <= 1'b0;
      r_we      <= 1'b0;
      alu_start <= 1'b0;
    end else begin
      d_we      <= 1'b0;
      r_we      <= 1'b0;
      alu_start <= 1'b0;
      case (state)
        IDLE: begin
          if (in.valid) begin
            op                 <= opcode_t'(in.mode);
            lit                <= in.literal;
            out.popped_value   <= '0;
            out.status         <= ST_OK;
            state              <= READ_T;
          end
        end
        READ_T: state <= READ_N;
        READ_N: begin
          top   <= d_rdata;
          rtop  <= r_rdata;
          state <= WAIT_N;
        end
        WAIT_N: begin
          nxt   <= d_rdata;
          state <= CHECK;
        end
        CHECK: begin
          state <= REFRESH;
          case (op)
            OP_PUSH: begin
              if (dp >= DFull) out.status <= ST_DOVER;
              else begin
                d_we <= 1'b1; d_waddr <= dp[DataAw-1:0]; d_wdata <= lit; dp <= dp_p1;
              end
            end
            OP_DROP: begin
              if (dp == '0) out.status <= ST_DUNDER;
              else begin
                out.popped_value <= top[31:0]; dp <= dp_m1;
              end
            end
            OP_DUP, OP_QDUP: begin
              if (dp == '0) out.status <= ST_DUNDER;
              else if (op == OP_QDUP && top == '0) begin
              end else if (dp >= DFull) out.status <= ST_DOVER;
              else begin
                d_we <= 1'b1; d_waddr <= dp[DataAw-1:0]; d_wdata <= top; dp <= dp_p1;
              end
            end
            OP_OVER: begin
              if (dp < DataCw'(2)) out.status <= ST_DUNDER;
              else if (dp >= DFull) out.status <= ST_DOVER;
              else begin
                d_we <= 1'b1; d_waddr <= dp[DataAw-1:0]; d_wdata <= nxt; dp <= dp_p1;
              end
            end
            OP_SWAP: begin
              if (dp < DataCw'(2)) out.status <= ST_DUNDER;
              else begin
                d_we <= 1'b1; d_waddr <= dp_m1[DataAw-1:0]; d_wdata <= nxt;
                wval2 <= top; state <= WRITE2;
              end
            end
            OP_NOT, OP_NEG, OP_ABS: begin
              if (dp == '0) out.status <= ST_DUNDER;
              else begin
                d_we <= 1'b1; d_waddr <= dp_m1[DataAw-1:0];
                if (op == OP_NOT) d_wdata <= ~top;
                else if (op == OP_NEG || top[CellBits-1]) d_wdata <= -top;
                else d_wdata <= top;
              end
            end
            OP_AND, OP_OR, OP_XOR, OP_SHIFT, OP_ADD, OP_SUB, OP_DIVMOD, OP_DIV,
            OP_MOD, OP_MUL, OP_MAX, OP_MIN, OP_EQ, OP_LT, OP_GT: begin
              if (dp < DataCw'(2)) out.status <= ST_DUNDER;
              else if ((op == OP_DIVMOD || op == OP_DIV || op == OP_MOD) && top == '0)
                out.status <= ST_DIVZ;
              else begin
                alu_start <= 1'b1; state <= EXEC;
              end
            end
            OP_TOR: begin
              if (dp == '0) out.status <= ST_DUNDER;
              else if (rp >= RFull) out.status <= ST_ROVER;
              else begin
                r_we <= 1'b1; r_waddr <= rp[ReturnAw-1:0]; r_wdata <= top;
                rp <= rp_p1; dp <= dp_m1;
              end
            end
            OP_RFETCH, OP_RFROM: begin
              if (rp == '0) out.status <= ST_RUNDER;
              else if (dp >= DFull) out.status <= ST_DOVER;
              else begin
                d_we <= 1'b1; d_waddr <= dp[DataAw-1:0]; d_wdata <= rtop; dp <= dp_p1;
                if (op == OP_RFROM) rp <= rp_m1;
              end
            end
            OP_DCLR: dp <= '0;
            OP_RCLR: rp <= '0;
            default: ;
          endcase
        end
        EXEC: state <= ALU_WAIT;
        ALU_WAIT: begin
          if (alu_done) begin
            d_we    <= 1'b1;
            d_waddr <= dp_m2[DataAw-1:0];
            if (op == OP_DIVMOD) begin
              d_wdata <= alu_rem;
              wval2   <= alu_res;
              state   <= WRITE2;
            end else begin
              d_wdata <= alu_res;
              dp      <= dp_m1;
              state   <= REFRESH;
            end
          end
        end
        WRITE2: begin
          // second write: quotient on top for /mod, old top below for swap
          d_we    <= 1'b1;
          d_waddr <= (op == OP_SWAP) ? dp_m2[DataAw-1:0] : dp_m1[DataAw-1:0];
          d_wdata <= wval2;
          state   <= REFRESH;
        end
        REFRESH: state <= REFRESH_W;
        REFRESH_W: state <= RESULT;
        RESULT: begin
          if (!out.valid) begin
            out.valid        <= 1'b1;
            out.top_value    <= (dp == '0) ? 32'd0 : d_rdata[31:0];
            out.data_count   <= 6'(dp);
            out.return_count <= 6'(rp);
          end else if (out.ready) begin
            out.valid <= 1'b0;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: design/fsa_checker.sv
module fsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  data_count,
  input logic [5:0]  return_count,
  input logic [2:0]  status
);
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> data_count <= 6'd32 && return_count <= 6'd32)
    else $error("depth out of range");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= 3'd5) else $error("bad status");
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid) else $error("no busy after accept");
endmodule

bind forth_stack_alu fsa_checker u_fsa_checker (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .data_count(out.data_count),
  .return_count(out.return_count), .status(out.status)
);
